>>> hdl/uer_pkg.sv
// Shared types, codes and constants for the ultrasonic echo ranger.
package uer_pkg;

    // Default width of the prescaled timer.
    localparam int UER_COUNT_BITS = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PRESCALE_DIV  = 2'd0;
    localparam logic [1:0] CFG_PULSE_TICKS   = 2'd1;
    localparam logic [1:0] CFG_START_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_ECHO_LIMIT    = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] RST_PRESCALE_DIV  = 16'd256;
    localparam logic [15:0] RST_PULSE_TICKS   = 16'd160;
    localparam logic [15:0] RST_START_TIMEOUT = 16'd6250;
    localparam logic [14:0] RST_ECHO_LIMIT    = 15'd1500;

    // Measurement phase codes.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_GUARD = 3'd1;
    localparam logic [2:0] PH_TRIG  = 3'd2;
    localparam logic [2:0] PH_WAIT  = 3'd3;
    localparam logic [2:0] PH_MEAS  = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOECHO = 2'd1;
    localparam logic [1:0] ST_CLIP   = 2'd2;

    // Count to millimetres: count * 343 / 125, done as count * (343 * ceil(2^30 / 125)) >> 30.
    // The product is exact for every count below the saturation point.
    localparam int          MM_IN_BITS    = 15;
    localparam int          MM_RECIP_BITS = 32;
    localparam int          MM_SHIFT      = 30;
    localparam int          DIST_BITS     = 16;
    localparam logic [31:0] MM_RECIP      = 32'd2946347705;
    localparam int          SAT_COUNT     = 23884;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] prescale_div;
        logic [15:0] pulse_ticks;
        logic [15:0] start_timeout;
        logic [14:0] echo_limit;
    } t_cfg;

    // One result beat.
    typedef struct packed {
        logic                 trigger;
        logic                 busy_res;
        logic                 done_res;
        logic [1:0]           status;
        logic [DIST_BITS-1:0] distance_mm;
    } t_result;

endpackage

>>> hdl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: configuration registers, timing engine, result buffer.
//
// Each input beat is one tick of the pin timing: a start request and the sampled echo level.
// Every accepted beat yields exactly one result beat, with the trigger level, a busy flag, and,
// on the tick a measurement ends, done with its status (0 ok, 1 no echo, 2 clipped) and the
// distance in millimetres, count * 343 / 125 truncated and saturated at 65535. A start waits
// pulse_ticks ticks, drives the trigger for pulse_ticks ticks, then counts prescaled timer
// counts while the echo is awaited and while it is high. The block takes one beat per clock
// cycle while o_stall is low; results are registered in a two-entry result buffer, which lets
// one more input beat be taken while the output is stalled. The
// critical path runs from the timer register through the count-to-distance multiplier into
// the result register. Configuration is to be written only while no measurement is running.
module ultrasonic_echo_ranger import uer_pkg::*; #(
    parameter int COUNT_BITS = UER_COUNT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input tick channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_start_req,
    input  logic                 i_echo,
    // Result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_trigger,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic [1:0]           o_status,
    output logic [DIST_BITS-1:0] o_distance_mm,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cfg    r_cfg;
    t_result w_result;
    t_result w_out;
    logic    w_accept;

    // Configuration registers; every write is taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prescale_div  <= RST_PRESCALE_DIV;
            r_cfg.pulse_ticks   <= RST_PULSE_TICKS;
            r_cfg.start_timeout <= RST_START_TIMEOUT;
            r_cfg.echo_limit    <= RST_ECHO_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PRESCALE_DIV:  r_cfg.prescale_div  <= i_cfg_data;
                CFG_PULSE_TICKS:   r_cfg.pulse_ticks   <= i_cfg_data;
                CFG_START_TIMEOUT: r_cfg.start_timeout <= i_cfg_data;
                CFG_ECHO_LIMIT:    r_cfg.echo_limit    <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // An input beat is taken whenever the result buffer has room.
    assign w_accept = i_valid && !o_stall;

    uer_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_start_req (i_start_req),
        .i_echo      (i_echo),
        .i_cfg       (r_cfg),
        .o_result    (w_result)
    );

    uer_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_result (w_result),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .o_result (w_out),
        .i_stall  (i_stall)
    );

    assign o_trigger     = w_out.trigger;
    assign o_busy_res    = w_out.busy_res;
    assign o_done_res    = w_out.done_res;
    assign o_status      = w_out.status;
    assign o_distance_mm = w_out.distance_mm;

endmodule

>>> hdl/uer_to_mm.sv
// Conversion of a timer count into a saturated distance in millimetres.
module uer_to_mm import uer_pkg::*; #(
    parameter int COUNT_BITS = UER_COUNT_BITS
) (
    input  logic [COUNT_BITS-1:0] i_count,
    output logic [DIST_BITS-1:0]  o_mm
);

    localparam int CW     = (COUNT_BITS > MM_IN_BITS) ? COUNT_BITS : MM_IN_BITS;
    localparam int PROD_W = MM_IN_BITS + MM_RECIP_BITS;

    logic [CW-1:0]         w_count_ext;
    logic                  w_sat;
    logic [MM_IN_BITS-1:0] w_small;
    logic [PROD_W-1:0]     w_prod;

    // Counts at or above the saturation point give the top distance.
    assign w_count_ext = CW'(i_count);
    assign w_sat       = w_count_ext >= CW'(SAT_COUNT);
    assign w_small     = w_count_ext[MM_IN_BITS-1:0];

    // Reciprocal multiply replaces the divide by 125.
    assign w_prod = PROD_W'(w_small) * PROD_W'(MM_RECIP);
    assign o_mm   = w_sat ? {DIST_BITS{1'b1}} : w_prod[MM_SHIFT+DIST_BITS-1:MM_SHIFT];

endmodule

>>> hdl/uer_core.sv
// Pulse timing state machine: guard, trigger, echo wait and echo measurement.
module uer_core import uer_pkg::*; #(
    parameter int COUNT_BITS = UER_COUNT_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_start_req,
    input  logic    i_echo,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int BW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [2:0]            r_phase, n_phase;
    logic [15:0]           r_tick_count, n_tick_count;
    logic [15:0]           r_prescale_count, n_prescale_count;
    logic [COUNT_BITS-1:0] r_timer_count, n_timer_count;

    logic [16:0]           w_tick_next;
    logic                  w_tick_end;
    logic [16:0]           w_pre_next;
    logic                  w_pre_wrap;
    logic                  w_timer_top;
    logic [COUNT_BITS-1:0] w_timer_inc;
    logic [BW-1:0]         w_timer_ext;
    logic                  w_wait_bound;
    logic                  w_meas_bound;
    logic [DIST_BITS-1:0]  w_mm;
    t_result               w_res;

    // Tick counter for the guard and trigger phases.
    assign w_tick_next = 17'(r_tick_count) + 17'd1;
    assign w_tick_end  = w_tick_next >= 17'(i_cfg.pulse_ticks);

    // Prescaler and timer advance; the timer holds at its top value.
    assign w_pre_next  = 17'(r_prescale_count) + 17'd1;
    assign w_pre_wrap  = w_pre_next >= 17'(i_cfg.prescale_div);
    assign w_timer_top = r_timer_count == {COUNT_BITS{1'b1}};
    assign w_timer_inc = w_timer_top ? r_timer_count : r_timer_count + COUNT_BITS'(1);

    // Bounds of the wait and measure phases.
    assign w_timer_ext  = BW'(r_timer_count);
    assign w_wait_bound = (w_timer_ext >= BW'(i_cfg.start_timeout)) || w_timer_top;
    assign w_meas_bound = (w_timer_ext >= BW'(i_cfg.echo_limit)) || w_timer_top;

    // Distance of the count reached so far.
    uer_to_mm #(
        .COUNT_BITS (COUNT_BITS)
    ) u_to_mm (
        .i_count (r_timer_count),
        .o_mm    (w_mm)
    );

    // Next state and result of one tick.
    always_comb begin
        n_phase          = r_phase;
        n_tick_count     = r_tick_count;
        n_prescale_count = r_prescale_count;
        n_timer_count    = r_timer_count;
        w_res            = '0;
        case (r_phase)
            PH_GUARD, PH_TRIG: begin
                if (w_tick_end) begin
                    n_tick_count = '0;
                    if (r_phase == PH_GUARD) begin
                        n_phase = PH_TRIG;
                    end else begin
                        n_phase          = PH_WAIT;
                        n_prescale_count = '0;
                        n_timer_count    = '0;
                    end
                end else begin
                    n_tick_count = w_tick_next[15:0];
                end
            end
            PH_WAIT: begin
                if (i_echo) begin
                    n_phase          = PH_MEAS;
                    n_prescale_count = '0;
                    n_timer_count    = '0;
                end else if (w_wait_bound) begin
                    n_phase         = PH_IDLE;
                    w_res.done_res  = 1'b1;
                    w_res.status    = ST_NOECHO;
                end else if (w_pre_wrap) begin
                    n_prescale_count = '0;
                    n_timer_count    = w_timer_inc;
                end else begin
                    n_prescale_count = w_pre_next[15:0];
                end
            end
            PH_MEAS: begin
                if (!i_echo) begin
                    n_phase           = PH_IDLE;
                    w_res.done_res    = 1'b1;
                    w_res.status      = ST_OK;
                    w_res.distance_mm = w_mm;
                end else if (w_meas_bound) begin
                    n_phase           = PH_IDLE;
                    w_res.done_res    = 1'b1;
                    w_res.status      = ST_CLIP;
                    w_res.distance_mm = w_mm;
                end else if (w_pre_wrap) begin
                    n_prescale_count = '0;
                    n_timer_count    = w_timer_inc;
                end else begin
                    n_prescale_count = w_pre_next[15:0];
                end
            end
            default: begin
                // Idle, and any code that means nothing, waits for a start.
                n_phase = PH_IDLE;
                if (i_start_req) begin
                    n_phase      = PH_GUARD;
                    n_tick_count = '0;
                end
            end
        endcase
        w_res.trigger  = n_phase == PH_TRIG;
        w_res.busy_res = n_phase != PH_IDLE;
    end

    assign o_result = w_res;

    // State advances once for every accepted input beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_tick_count     <= '0;
            r_prescale_count <= '0;
            r_timer_count    <= '0;
        end else if (i_accept) begin
            r_phase          <= n_phase;
            r_tick_count     <= n_tick_count;
            r_prescale_count <= n_prescale_count;
            r_timer_count    <= n_timer_count;
        end
    end

    // A finished measurement leaves the block idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done_res |-> !w_res.busy_res)
        else $error("result given while still busy");

    // The trigger is only driven during a measurement.
    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.trigger |-> w_res.busy_res)
        else $error("trigger high outside a measurement");

    // Status and distance are zero on ticks without a result.
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_res.done_res |-> (w_res.status == ST_OK && w_res.distance_mm == '0))
        else $error("status or distance set without a result");

endmodule

>>> hdl/uer_out_buf.sv
// Result register with a skid stage so that one more input beat is taken under output stall.
module uer_out_buf import uer_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    output logic    o_stall,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_stall
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    w_accept;
    logic    w_take;

    assign w_accept = i_valid && !r_skid_valid;
    assign w_take   = r_main_valid && !i_stall;

    // Control: the skid entry fills only while the main entry is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= w_accept;
            end
        end else if (w_accept) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // Payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (w_accept) begin
                r_main <= i_result;
            end
        end else if (w_accept) begin
            if (r_main_valid) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

    assign o_stall  = r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

    // The skid entry is never used while the main entry is empty.
    a_skid_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry holds a beat ahead of the main entry");

    // A full buffer that is not drained stays full.
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_stall) |=> (r_skid_valid && r_main_valid))
        else $error("beat lost from a stalled buffer");

    // A waiting result is not dropped.
    a_main_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && i_stall) |=> r_main_valid)
        else $error("stalled result dropped");

endmodule
